// ===== rtl/esc_pkg.sv =====
// esc_pkg: constants, month table and result layout for the epoch seconds to calendar block
// no dependencies; imported by esc_cdiv and epoch_seconds_to_calendar

package esc_pkg;

	// width of the partial dividend handled by one divider step
	localparam int STEP_W = 31;

	// 86400 = 675 << 7
	localparam int SEC_LOW_W = 7;
	localparam int DAY_ODD = 675;
	localparam int DAY_ODD_REM_W = 10;
	localparam int TOD_W = 17;

	localparam int DAYS_400Y = 146097;
	localparam int DAYS_400Y_REM_W = 18;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_100Y_REM_W = 16;
	localparam int DAYS_4Y = 1461;
	localparam int DAYS_4Y_REM_W = 11;
	localparam int DAYS_1Y = 365;
	localparam int DAYS_1Y_REM_W = 9;
	localparam int SECS_HOUR = 3600;
	localparam int SECS_HOUR_REM_W = 12;
	localparam int SECS_MIN = 60;
	localparam int SECS_MIN_REM_W = 6;

	localparam logic [3:0] MONTH_FEB = 4'd1;
	localparam int MONTHS = 12;

	localparam logic [8:0] MONTH_START [MONTHS] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// first field in the highest bits
	typedef struct packed {
		logic [8:0]  yearday_out;
		logic [5:0]  second_out;
		logic [5:0]  minute_out;
		logic [4:0]  hour_out;
		logic [4:0]  day_of_month_out;
		logic [3:0]  month_out;
		logic [15:0] year_out;
	} result_t;

	localparam int RES_W = $bits(result_t);
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
		logic [8:0] base;
		base = MONTH_START[month];
		if (leap && month > MONTH_FEB) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar.sv =====
// epoch_seconds_to_calendar: seconds since 1 January of BASE_YEAR to Gregorian date and time
// depends on esc_pkg and esc_cdiv

// Takes one transfer per clock while s_axis_tready is high and returns one result transfer per
// input, in order. The input passes through a chain of constant dividers (675, 146097, 36524,
// 1461, 365, 3600, 60), each taking two stages per 31-bit partial dividend, plus five stages of
// date logic and the output register. The output register has one spare entry, so s_axis_tready
// comes straight from a flop and the pipeline halts as a whole while the spare entry is occupied.

module epoch_seconds_to_calendar
	import esc_pkg::*;
#(
	parameter int BASE_YEAR = 1970,
	parameter int SECONDS_WIDTH = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// total_seconds
	input  logic [((SECONDS_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// year_out, month_out, day_of_month_out, hour_out, minute_out, second_out, yearday_out
	output logic [OUT_W-1:0]                     m_axis_tdata
);

	localparam int QUO1_W = SECONDS_WIDTH - SEC_LOW_W;
	localparam int DAY_W = SECONDS_WIDTH - 16;
	localparam longint unsigned PRIOR = BASE_YEAR - 1;
	localparam longint unsigned D0 = PRIOR * 365 + PRIOR / 4 - PRIOR / 100 + PRIOR / 400;
	localparam int D0_W = $clog2(D0 + 1);
	localparam int NB_W = (DAY_W > D0_W) ? DAY_W : D0_W;
	localparam int N_W = ((NB_W > 17) ? NB_W : 17) + 1;
	localparam int Q400_W = N_W - 17;
	localparam int YEAR_W = Q400_W + 10;
	localparam int SIDE3_W = Q400_W + TOD_W;
	localparam int SIDE4_W = SIDE3_W + 2;
	localparam int SIDE5_W = SIDE4_W + 5;
	localparam int SIDE6_W = YEAR_W + 1 + 9;
	localparam int SIDE7_W = SIDE6_W + 5;

	logic adv;
	logic [SECONDS_WIDTH-1:0] secs;

	// days and time of day
	logic                      d1_vld;
	logic [QUO1_W-1:0]         d1_quo;
	logic [DAY_ODD_REM_W-1:0]  d1_rem;
	logic [SEC_LOW_W-1:0]      d1_side;

	logic                      vld_s1;
	logic [N_W-1:0]            n_s1;
	logic [TOD_W-1:0]          tod_s1;

	logic                      d2_vld;
	logic [N_W-1:0]            d2_quo;
	logic [DAYS_400Y_REM_W-1:0] d2_rem;
	logic [TOD_W-1:0]          d2_side;

	logic                      d3_vld;
	logic [DAYS_400Y_REM_W-1:0] d3_quo;
	logic [DAYS_100Y_REM_W-1:0] d3_rem;
	logic [SIDE3_W-1:0]        d3_side;

	logic                      vld_s2;
	logic [1:0]                q100_s2;
	logic [16:0]               r100_s2;
	logic [SIDE3_W-1:0]        side_s2;

	logic                      d4_vld;
	logic [16:0]               d4_quo;
	logic [DAYS_4Y_REM_W-1:0]  d4_rem;
	logic [SIDE4_W-1:0]        d4_side;

	logic                      d5_vld;
	logic [DAYS_4Y_REM_W-1:0]  d5_quo;
	logic [DAYS_1Y_REM_W-1:0]  d5_rem;
	logic [SIDE5_W-1:0]        d5_side;

	logic [Q400_W-1:0]         q400_c;
	logic [TOD_W-1:0]          tod_c;
	logic [1:0]                q100_c;
	logic [4:0]                q4_c;
	logic [1:0]                q1_c;
	logic [8:0]                yday_c;

	logic                      vld_s3;
	logic [YEAR_W-1:0]         year_s3;
	logic                      leap_s3;
	logic [8:0]                yday_s3;
	logic [TOD_W-1:0]          tod_s3;

	logic                      d6_vld;
	logic [TOD_W-1:0]          d6_quo;
	logic [SECS_HOUR_REM_W-1:0] d6_rem;
	logic [SIDE6_W-1:0]        d6_side;

	logic                      d7_vld;
	logic [SECS_HOUR_REM_W-1:0] d7_quo;
	logic [SECS_MIN_REM_W-1:0] d7_rem;
	logic [SIDE7_W-1:0]        d7_side;

	logic [YEAR_W-1:0]         year_c;
	logic                      leap_c;
	logic [8:0]                yday_s3_c;
	logic [4:0]                hour_c;
	logic [3:0]                mon_c;
	logic [8:0]                base_c;

	logic                      vld_s4;
	logic [YEAR_W-1:0]         year_s4;
	logic [3:0]                mon_s4;
	logic [8:0]                base_s4;
	logic [8:0]                yday_s4;
	logic [4:0]                hour_s4;
	logic [5:0]                minute_s4;
	logic [5:0]                second_s4;

	logic                      vld_s5;
	result_t                   res_s5;

	logic                      out_v_q;
	result_t                   out_q;
	logic                      spare_v_q;
	result_t                   spare_q;
	logic                      out_take;
	logic                      push;

	assign adv = !spare_v_q;
	assign s_axis_tready = adv;
	assign secs = s_axis_tdata[SECONDS_WIDTH-1:0];

	esc_cdiv #(
		.DIVISOR (DAY_ODD),
		.NUM_W   (QUO1_W),
		.REM_W   (DAY_ODD_REM_W),
		.SIDE_W  (SEC_LOW_W)
	) u_div_day (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_axis_tvalid),
		.in_num    (secs[SECONDS_WIDTH-1:SEC_LOW_W]),
		.in_side   (secs[SEC_LOW_W-1:0]),
		.out_valid (d1_vld),
		.out_quo   (d1_quo),
		.out_rem   (d1_rem),
		.out_side  (d1_side)
	);

	// day number counted from 1 January of year 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= d1_vld;
			vld_s2 <= d3_vld;
			vld_s3 <= d5_vld;
			vld_s4 <= d7_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1   <= N_W'(d1_quo[DAY_W-1:0]) + N_W'(D0);
			tod_s1 <= {d1_rem, d1_side};
		end
	end

	esc_cdiv #(
		.DIVISOR (DAYS_400Y),
		.NUM_W   (N_W),
		.REM_W   (DAYS_400Y_REM_W),
		.SIDE_W  (TOD_W)
	) u_div_400y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.in_num    (n_s1),
		.in_side   (tod_s1),
		.out_valid (d2_vld),
		.out_quo   (d2_quo),
		.out_rem   (d2_rem),
		.out_side  (d2_side)
	);

	esc_cdiv #(
		.DIVISOR (DAYS_100Y),
		.NUM_W   (DAYS_400Y_REM_W),
		.REM_W   (DAYS_100Y_REM_W),
		.SIDE_W  (SIDE3_W)
	) u_div_100y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d2_vld),
		.in_num    (d2_rem),
		.in_side   ({d2_quo[Q400_W-1:0], d2_side}),
		.out_valid (d3_vld),
		.out_quo   (d3_quo),
		.out_rem   (d3_rem),
		.out_side  (d3_side)
	);

	// last day of a 400 year cycle stays in the fourth century
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= d3_side;
			if (d3_quo[2:0] == 3'd4) begin
				q100_s2 <= 2'd3;
				r100_s2 <= 17'(DAYS_100Y);
			end else begin
				q100_s2 <= d3_quo[1:0];
				r100_s2 <= {1'b0, d3_rem};
			end
		end
	end

	esc_cdiv #(
		.DIVISOR (DAYS_4Y),
		.NUM_W   (17),
		.REM_W   (DAYS_4Y_REM_W),
		.SIDE_W  (SIDE4_W)
	) u_div_4y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.in_num    (r100_s2),
		.in_side   ({side_s2, q100_s2}),
		.out_valid (d4_vld),
		.out_quo   (d4_quo),
		.out_rem   (d4_rem),
		.out_side  (d4_side)
	);

	esc_cdiv #(
		.DIVISOR (DAYS_1Y),
		.NUM_W   (DAYS_4Y_REM_W),
		.REM_W   (DAYS_1Y_REM_W),
		.SIDE_W  (SIDE5_W)
	) u_div_1y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d4_vld),
		.in_num    (d4_rem),
		.in_side   ({d4_side, d4_quo[4:0]}),
		.out_valid (d5_vld),
		.out_quo   (d5_quo),
		.out_rem   (d5_rem),
		.out_side  (d5_side)
	);

	// last day of a 4 year cycle stays in the fourth year
	always_comb begin
		{q400_c, tod_c, q100_c, q4_c} = d5_side;
		if (d5_quo[2:0] == 3'd4) begin
			q1_c   = 2'd3;
			yday_c = 9'(DAYS_1Y);
		end else begin
			q1_c   = d5_quo[1:0];
			yday_c = d5_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			year_s3 <= YEAR_W'(1) + YEAR_W'(q400_c) * YEAR_W'(400)
				+ YEAR_W'(q100_c) * YEAR_W'(100) + YEAR_W'(q4_c) * YEAR_W'(4)
				+ YEAR_W'(q1_c);
			leap_s3 <= (q1_c == 2'd3) && ((q4_c != 5'd24) || (q100_c == 2'd3));
			yday_s3 <= yday_c;
			tod_s3  <= tod_c;
		end
	end

	esc_cdiv #(
		.DIVISOR (SECS_HOUR),
		.NUM_W   (TOD_W),
		.REM_W   (SECS_HOUR_REM_W),
		.SIDE_W  (SIDE6_W)
	) u_div_hour (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.in_num    (tod_s3),
		.in_side   ({year_s3, leap_s3, yday_s3}),
		.out_valid (d6_vld),
		.out_quo   (d6_quo),
		.out_rem   (d6_rem),
		.out_side  (d6_side)
	);

	esc_cdiv #(
		.DIVISOR (SECS_MIN),
		.NUM_W   (SECS_HOUR_REM_W),
		.REM_W   (SECS_MIN_REM_W),
		.SIDE_W  (SIDE7_W)
	) u_div_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d6_vld),
		.in_num    (d6_rem),
		.in_side   ({d6_side, d6_quo[4:0]}),
		.out_valid (d7_vld),
		.out_quo   (d7_quo),
		.out_rem   (d7_rem),
		.out_side  (d7_side)
	);

	// month lookup against the start of each month
	always_comb begin
		logic [8:0] st;
		{year_c, leap_c, yday_s3_c, hour_c} = d7_side;
		mon_c  = 4'd0;
		base_c = 9'd0;
		for (int m = 1; m < MONTHS; m++) begin
			st = month_start(4'(m), leap_c);
			if (yday_s3_c >= st) begin
				mon_c  = 4'(m);
				base_c = st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			year_s4   <= year_c;
			mon_s4    <= mon_c;
			base_s4   <= base_c;
			yday_s4   <= yday_s3_c;
			hour_s4   <= hour_c;
			minute_s4 <= d7_quo[5:0];
			second_s4 <= d7_rem;

			res_s5.year_out         <= 16'(year_s4);
			res_s5.month_out        <= mon_s4;
			res_s5.day_of_month_out <= 5'(yday_s4 - base_s4);
			res_s5.hour_out         <= hour_s4;
			res_s5.minute_out       <= minute_s4;
			res_s5.second_out       <= second_s4;
			res_s5.yearday_out      <= yday_s4;
		end
	end

	// output register with one spare entry
	assign out_take = out_v_q && m_axis_tready;
	assign push = adv && vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else begin
			if (spare_v_q) begin
				if (out_take) begin
					spare_v_q <= 1'b0;
				end
			end else if (push) begin
				if (out_v_q && !m_axis_tready) begin
					spare_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (out_take) begin
				out_q <= spare_q;
			end
		end else if (push) begin
			if (out_v_q && !m_axis_tready) begin
				spare_q <= res_s5;
			end else begin
				out_q <= res_s5;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, out_q};

	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> out_v_q)
		else $error("spare entry occupied while output register empty");

	a_spare_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spare_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("spare entry filled without a stalled output");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.month_out <= 4'd11) && (out_q.hour_out <= 5'd23)
			&& (out_q.minute_out <= 6'd59) && (out_q.second_out <= 6'd59))
		else $error("calendar field out of range");

	a_january_days: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_q.month_out == 4'd0)) |->
			(out_q.yearday_out == {4'd0, out_q.day_of_month_out}))
		else $error("january day of month disagrees with day of year");

endmodule

// ===== rtl/esc_cdiv.sv =====
// esc_cdiv: pipelined division by a constant, one digit group per step, two stages per step
// depends on esc_pkg for the step width

module esc_cdiv
	import esc_pkg::*;
#(
	parameter longint unsigned DIVISOR = 675,
	parameter int NUM_W = 33,
	parameter int REM_W = 10,
	parameter int SIDE_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [REM_W-1:0]  out_rem,
	output logic [SIDE_W-1:0] out_side
);

	localparam int DIG_W = STEP_W - REM_W;
	localparam int STEPS = (NUM_W + DIG_W - 1) / DIG_W;
	localparam int PAD_W = STEPS * DIG_W;
	localparam int SHIFT = STEP_W + REM_W;
	localparam int RCP_W = STEP_W + 1;
	localparam longint unsigned RCP = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
	localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);
	localparam logic [STEP_W-1:0] DIV_V = STEP_W'(DIVISOR);

	logic              vld_s1  [STEPS];
	logic [STEP_W-1:0] v_s1    [STEPS];
	logic [DIG_W-1:0]  qd_s1   [STEPS];
	logic [PAD_W-1:0]  num_s1  [STEPS];
	logic [PAD_W-1:0]  quo_s1  [STEPS];
	logic [SIDE_W-1:0] side_s1 [STEPS];

	logic              vld_s2  [STEPS];
	logic [REM_W-1:0]  rem_s2  [STEPS];
	logic [PAD_W-1:0]  num_s2  [STEPS];
	logic [PAD_W-1:0]  quo_s2  [STEPS];
	logic [SIDE_W-1:0] side_s2 [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                    vin;
		logic [REM_W-1:0]        rin;
		logic [PAD_W-1:0]        nin;
		logic [PAD_W-1:0]        qin;
		logic [SIDE_W-1:0]       sin;
		logic [STEP_W-1:0]       v;
		logic [STEP_W+RCP_W-1:0] prod;
		logic [STEP_W-1:0]       back;
		logic [STEP_W-1:0]       diff;

		if (i == 0) begin : g_first
			assign vin = in_valid;
			assign rin = '0;
			assign nin = PAD_W'(in_num);
			assign qin = '0;
			assign sin = in_side;
		end else begin : g_next
			assign vin = vld_s2[i-1];
			assign rin = rem_s2[i-1];
			assign nin = num_s2[i-1];
			assign qin = quo_s2[i-1];
			assign sin = side_s2[i-1];
		end

		// partial remainder followed by the next digit group
		assign v = {rin, nin[PAD_W-1-i*DIG_W -: DIG_W]};
		assign prod = {{RCP_W{1'b0}}, v} * {{STEP_W{1'b0}}, RCP_V};
		assign back = {{REM_W{1'b0}}, qd_s1[i]} * DIV_V;
		assign diff = v_s1[i] - back;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i] <= 1'b0;
				vld_s2[i] <= 1'b0;
			end else if (en) begin
				vld_s1[i] <= vin;
				vld_s2[i] <= vld_s1[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s1[i]    <= v;
				qd_s1[i]   <= prod[SHIFT +: DIG_W];
				num_s1[i]  <= nin;
				quo_s1[i]  <= qin;
				side_s1[i] <= sin;
				rem_s2[i]  <= diff[REM_W-1:0];
				num_s2[i]  <= num_s1[i];
				quo_s2[i]  <= (quo_s1[i] << DIG_W) | PAD_W'(qd_s1[i]);
				side_s2[i] <= side_s1[i];
			end
		end
	end

	assign out_valid = vld_s2[STEPS-1];
	assign out_quo   = quo_s2[STEPS-1][NUM_W-1:0];
	assign out_rem   = rem_s2[STEPS-1];
	assign out_side  = side_s2[STEPS-1];

endmodule

// ===== verif/epoch_seconds_to_calendar_test.sv =====
// epoch_seconds_to_calendar_test: self-checking bench for the seconds to calendar date converter
// drives timestamps over the input stream and checks every date and time of day on the output
// depends on esc_pkg and epoch_seconds_to_calendar

`timescale 1ns / 1ps

module epoch_seconds_to_calendar_test;
	import esc_pkg::*;

	localparam int EPOCH = 1970;
	localparam int SEC_W = 40;
	localparam int IN_W = ((SEC_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1430;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_PCT = 22;
	localparam longint unsigned SECS_DAY = 86400;
	localparam longint unsigned LAST_DAY = ((64'd1 << SEC_W) - 1) / SECS_DAY - 1;
	localparam longint unsigned EPOCH_PREV = EPOCH - 1;
	localparam longint unsigned EPOCH_DAY0 =
		EPOCH_PREV * 365 + EPOCH_PREV / 4 - EPOCH_PREV / 100 + EPOCH_PREV / 400;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		logic [SEC_W-1:0] secs;
		bit               typed;
		result_t          want;
	} stamp_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// total_seconds
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// year_out, month_out, day_of_month_out, hour_out, minute_out, second_out, yearday_out
	logic [OUT_W-1:0] m_axis_tdata;

	result_t     calendar_due_q [$];
	stamp_case_t stamp_tab [20];
	int unsigned mismatches = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	epoch_seconds_to_calendar #(
		.BASE_YEAR(EPOCH),
		.SECONDS_WIDTH(SEC_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t civil(input int unsigned yr, input int unsigned mon,
			input int unsigned mday, input int unsigned hh, input int unsigned mm,
			input int unsigned ss, input int unsigned yday);
		result_t res;
		res.year_out = 16'(yr);
		res.month_out = 4'(mon);
		res.day_of_month_out = 5'(mday);
		res.hour_out = 5'(hh);
		res.minute_out = 6'(mm);
		res.second_out = 6'(ss);
		res.yearday_out = 9'(yday);
		return res;
	endfunction

	function automatic result_t calendar_of(input logic [SEC_W-1:0] secs);
		longint unsigned days, tod, n, r, q400, q100, q4, q1, yr, left, mlen;
		logic [3:0] mon;
		logic [4:0] mday;
		bit leap_yr, found;
		result_t res;
		days = secs / SECS_DAY;
		tod = secs % SECS_DAY;
		n = EPOCH_DAY0 + days;
		q400 = n / 146097;
		r = n % 146097;
		q100 = r / 36524;
		if (q100 == 4) q100 = 3;
		r = r - q100 * 36524;
		q4 = r / 1461;
		r = r % 1461;
		q1 = r / 365;
		if (q1 == 4) q1 = 3;
		r = r - q1 * 365;
		yr = 1 + q400 * 400 + q100 * 100 + q4 * 4 + q1;
		leap_yr = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
		left = r;
		mon = 4'd11;
		mday = 5'd0;
		found = 1'b0;
		for (int m = 0; m < 12; m++) begin
			mlen = MONTH_DAYS[m] + ((m == 1 && leap_yr) ? 1 : 0);
			if (!found && left < mlen) begin
				mon = 4'(m);
				mday = 5'(left);
				found = 1'b1;
			end else if (!found) begin
				left = left - mlen;
			end
		end
		res.year_out = 16'(yr);
		res.month_out = mon;
		res.day_of_month_out = mday;
		res.hour_out = 5'(tod / 3600);
		res.minute_out = 6'((tod % 3600) / 60);
		res.second_out = 6'(tod % 60);
		res.yearday_out = 9'(r);
		return res;
	endfunction

	function automatic logic [SEC_W-1:0] random_seconds();
		longint unsigned d, t;
		case ($urandom_range(3))
			0: return {8'($urandom_range(255)), 32'($urandom)};
			1: return {8'd0, 32'($urandom)};
			2: begin
				d = $urandom_range(LAST_DAY);
				case ($urandom_range(2))
					0: t = 0;
					1: t = SECS_DAY - 1;
					default: t = $urandom_range(SECS_DAY - 1);
				endcase
				return SEC_W'(d * SECS_DAY + t);
			end
			default: return {8'($urandom_range(255)), 32'($urandom)};
		endcase
	endfunction

	task automatic send_seconds(input logic [SEC_W-1:0] secs, input bit typed,
			input result_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'(secs);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		calendar_due_q.push_back(typed ? want : calendar_of(secs));
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input logic [OUT_W-1:0] data);
		result_t want, got;
		got = result_t'(data[RES_W-1:0]);
		if (calendar_due_q.size() == 0) begin
			$error("unexpected output transfer: data %0h", data);
			mismatches++;
			return;
		end
		want = calendar_due_q.pop_front();
		check_field("year_out", want.year_out, got.year_out);
		check_field("month_out", want.month_out, got.month_out);
		check_field("day_of_month_out", want.day_of_month_out, got.day_of_month_out);
		check_field("hour_out", want.hour_out, got.hour_out);
		check_field("minute_out", want.minute_out, got.minute_out);
		check_field("second_out", want.second_out, got.second_out);
		check_field("yearday_out", want.yearday_out, got.yearday_out);
		check_field("padding", 0, data[OUT_W-1:RES_W]);
	endtask

	// output side: check each transfer, then pick the next tready
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		stamp_tab = '{
			'{40'd0, 1'b1, civil(1970, 0, 0, 0, 0, 0, 0)},
			'{40'd86399, 1'b1, civil(1970, 0, 0, 23, 59, 59, 0)},
			'{40'hFF_FFFF_FFFF, 1'b1, civil(36812, 1, 19, 0, 36, 15, 50)},
			'{40'd1, 1'b0, '0},
			'{40'd59, 1'b0, '0},
			'{40'd60, 1'b0, '0},
			'{40'd3599, 1'b0, '0},
			'{40'd3600, 1'b0, '0},
			'{40'd86400, 1'b0, '0},
			'{40'd68169600, 1'b0, '0},     // leap day 1972
			'{40'd94608000, 1'b0, '0},     // last day of a leap year
			'{40'd951782400, 1'b0, '0},    // leap day 2000, divisible by 400
			'{40'd978220800, 1'b0, '0},    // last day of 2000
			'{40'd4107456000, 1'b0, '0},   // 2100 is not leap
			'{40'd4107542400, 1'b0, '0},
			'{40'd13574563200, 1'b0, '0},  // leap day 2400
			'{40'hAA_AAAA_AAAA, 1'b0, '0},
			'{40'h55_5555_5555, 1'b0, '0},
			'{40'h80_0000_0000, 1'b0, '0},
			'{40'h00_FFFF_FFFF, 1'b0, '0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stamp_tab[i]) begin
			send_seconds(stamp_tab[i].secs, stamp_tab[i].typed, stamp_tab[i].want);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 500 && i < 800);
			if (i == 200) hold_req = 1'b1;
			if (i == 1100) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (calendar_due_q.size() != 0);
			end
			send_seconds(random_seconds(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;
		while (calendar_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/esc_pkg.sv
rtl/esc_cdiv.sv
rtl/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_test.sv
